>>> sv/tscd_pkg.sv
`timescale 1ns / 1ps
package tscd_pkg;
  localparam int MAX_NODES = 32;
  localparam int MAX_EDGES = 256;
  localparam int NW = 6;
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int SAW = $clog2(MAX_NODES);
  localparam int SCW = $clog2(MAX_NODES + 1);

  localparam logic [1:0] WHITE = 2'd0;
  localparam logic [1:0] GREY  = 2'd1;
  localparam logic [1:0] BLACK = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_SCAN_RD, S_SCAN, S_CHAIN, S_EMIT_START, S_EMIT_CHAIN,
    S_EMIT_END, S_EMIT_TOPO, S_EMIT_NONE, S_WAIT
  } state_t;

  typedef struct packed {
    logic load_edge;
    logic clear_graph;
    logic init_run;
    logic root_next;
    logic start_root;
    logic read_edge;
    logic scan_step;
    logic chain_step;
    logic emit_start;
    logic emit_chain;
    logic emit_end;
    logic emit_topo;
    logic emit_none;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_white;
    logic stack_empty;
    logic found;
    logic chain_done;
    logic chain_empty;
    logic fin_empty;
    logic fin_one;
  } stat_t;
endpackage

>>> sv/tscd_datapath.sv
`timescale 1ns / 1ps
module tscd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [5:0]         node_count,
  input  logic [5:0]         edge_from,
  input  logic [5:0]         edge_to,
  input  tscd_pkg::cmd_t     cmd,
  output tscd_pkg::stat_t    stat,
  output logic [9:0]         out_data,
  output logic               out_load
);
  import tscd_pkg::*;

  logic [NW-1:0] src_mem [MAX_EDGES];
  logic [NW-1:0] dst_mem [MAX_EDGES];
  logic [NW-1:0] rd_src, rd_dst;
  logic [ECW-1:0] edges_held;
  logic overflow_seen;
  logic [1:0] colour [MAX_NODES];
  logic [NW-1:0] parent [MAX_NODES];
  logic [NW-1:0] stk_node [MAX_NODES];
  logic [ECW-1:0] stk_cur [MAX_NODES];
  logic [NW-1:0] fin [MAX_NODES];
  logic [NW-1:0] chain [MAX_NODES];
  logic [SCW-1:0] sp, fc, cn;
  logic [NW:0] root;
  logic [ECW-1:0] e;
  logic [NW-1:0] cyc_start, cyc_end, walk;
  logic found;
  logic [NW:0] n_eff;
  logic [NW-1:0] top_v, u;
  logic e_end, match, push_ok;
  logic [ECW-1:0] cur_top;
  logic [EAW-1:0] rd_addr;

  assign n_eff = (node_count > NW'(MAX_NODES)) ? (NW+1)'(MAX_NODES) : {1'b0, node_count};
  assign top_v = stk_node[sp[SAW-1:0] - SAW'(1)];
  assign cur_top = stk_cur[sp[SAW-1:0] - SAW'(1)];
  assign e_end = (e >= edges_held);
  assign u = rd_dst;
  assign match = (rd_src == top_v) && ({1'b0, rd_dst} < n_eff);
  assign push_ok = (sp < SCW'(MAX_NODES));

  // The read is addressed by the cursor being loaded, so the compare cycle
  // sees the entry that e points at.
  assign rd_addr = cmd.read_edge ? cur_top[EAW-1:0] : e[EAW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_edge && {1'b0, edge_from} < n_eff && {1'b0, edge_to} < n_eff
        && edges_held < ECW'(MAX_EDGES)) begin
      src_mem[edges_held[EAW-1:0]] <= edge_from;
      dst_mem[edges_held[EAW-1:0]] <= edge_to;
    end
    rd_src <= src_mem[rd_addr];
    rd_dst <= dst_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges_held <= '0;
      overflow_seen <= 1'b0;
      sp <= '0;
      fc <= '0;
      cn <= '0;
      found <= 1'b0;
      root <= '0;
      e <= '0;
      for (int i = 0; i < MAX_NODES; i++) colour[i] <= WHITE;
    end else begin
      if (cmd.load_edge && {1'b0, edge_from} < n_eff && {1'b0, edge_to} < n_eff) begin
        if (edges_held < ECW'(MAX_EDGES)) edges_held <= edges_held + ECW'(1);
        else overflow_seen <= 1'b1;
      end
      if (cmd.clear_graph) begin
        edges_held <= '0;
        overflow_seen <= 1'b0;
      end
      if (cmd.init_run) begin
        for (int i = 0; i < MAX_NODES; i++) colour[i] <= WHITE;
        sp <= '0;
        fc <= '0;
        cn <= '0;
        found <= 1'b0;
        root <= '0;
      end
      if (cmd.root_next) root <= root + (NW+1)'(1);
      if (cmd.start_root) begin
        colour[root[SAW-1:0]] <= GREY;
        stk_node[0] <= root[NW-1:0];
        stk_cur[0] <= '0;
        e <= '0;
        sp <= SCW'(1);
      end
      if (cmd.read_edge) e <= cur_top;
      if (cmd.scan_step) begin
        if (e_end) begin
          colour[top_v[SAW-1:0]] <= BLACK;
          fin[fc[SAW-1:0]] <= top_v;
          fc <= fc + SCW'(1);
          sp <= sp - SCW'(1);
        end else if (!match) begin
          // Entries that do not leave the top node are skipped for good.
          stk_cur[sp[SAW-1:0] - SAW'(1)] <= e + ECW'(1);
          e <= e + ECW'(1);
        end else begin
          stk_cur[sp[SAW-1:0] - SAW'(1)] <= e + ECW'(1);
          if (colour[u[SAW-1:0]] == WHITE) begin
            if (push_ok) begin
              parent[u[SAW-1:0]] <= top_v;
              colour[u[SAW-1:0]] <= GREY;
              stk_node[sp[SAW-1:0]] <= u;
              stk_cur[sp[SAW-1:0]] <= '0;
              sp <= sp + SCW'(1);
            end
            e <= '0;
          end else if (colour[u[SAW-1:0]] == GREY) begin
            cyc_start <= u;
            cyc_end <= top_v;
            walk <= top_v;
            found <= 1'b1;
          end else begin
            e <= e + ECW'(1);
          end
        end
      end
      if (cmd.chain_step) begin
        chain[cn[SAW-1:0]] <= walk;
        cn <= cn + SCW'(1);
        walk <= parent[walk[SAW-1:0]];
      end
      if (cmd.emit_chain) cn <= cn - SCW'(1);
      if (cmd.emit_topo) fc <= fc - SCW'(1);
    end
  end

  // Pushes restart at the child's cursor of zero on the next read.
  always_comb begin
    stat.root_done = (root >= n_eff) || found;
    stat.root_white = colour[root[SAW-1:0]] == WHITE;
    stat.stack_empty = (sp == '0);
    stat.found = found;
    stat.chain_done = (walk == cyc_start) || (cn == SCW'(MAX_NODES));
    stat.chain_empty = (cn == '0);
    stat.fin_empty = (fc == '0);
    stat.fin_one = (fc == SCW'(1));
  end

  always_comb begin
    out_load = 1'b1;
    out_data = '0;
    if (cmd.emit_start || cmd.emit_end)
      out_data = {cmd.emit_end, overflow_seen, 1'b0, cyc_start, 1'b0};
    else if (cmd.emit_chain)
      out_data = {1'b0, overflow_seen, 1'b0, chain[cn[SAW-1:0] - SAW'(1)], 1'b0};
    else if (cmd.emit_topo)
      out_data = {(fc == SCW'(1)), overflow_seen, 1'b0, fin[fc[SAW-1:0] - SAW'(1)], 1'b1};
    else if (cmd.emit_none)
      out_data = {1'b1, overflow_seen, 1'b1, 6'd0, 1'b1};
    else out_load = 1'b0;
  end
endmodule

>>> sv/tscd_ctrl.sv
`timescale 1ns / 1ps
module tscd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             in_run,
  input  logic             nodes_zero,
  input  logic             out_free,
  input  tscd_pkg::stat_t  stat,
  output tscd_pkg::cmd_t   cmd,
  output logic             busy
);
  import tscd_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire && in_run) state_next = nodes_zero ? S_EMIT_NONE : S_ROOT;
      S_ROOT:
        if (stat.root_done) state_next = stat.found ? S_CHAIN : S_EMIT_TOPO;
        else if (stat.root_white) state_next = S_SCAN_RD;
      // A pop or a detected cycle shows up here, in the cycle after the compare.
      S_SCAN_RD: state_next = (stat.found || stat.stack_empty) ? S_ROOT : S_SCAN;
      S_SCAN: state_next = S_SCAN_RD;
      S_CHAIN: if (stat.chain_done) state_next = S_EMIT_START;
      S_EMIT_START: if (out_free) state_next = stat.chain_empty ? S_EMIT_END : S_EMIT_CHAIN;
      S_EMIT_CHAIN: if (out_free && cmd.emit_chain && stat.chain_empty) state_next = S_EMIT_END;
      S_EMIT_END: if (out_free) state_next = S_WAIT;
      S_EMIT_TOPO: if (out_free && stat.fin_one) state_next = S_WAIT;
      S_EMIT_NONE: if (out_free) state_next = S_WAIT;
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // The chain count is checked after the registered pop, once the output is free.
    if (state == S_EMIT_CHAIN && out_free && stat.chain_empty) state_next = S_EMIT_END;
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load_edge = in_fire && !in_run;
        cmd.init_run = in_fire && in_run;
      end
      S_ROOT: begin
        if (!stat.root_done) begin
          cmd.root_next = 1'b1;
          cmd.start_root = stat.root_white;
        end
      end
      S_SCAN_RD: cmd.read_edge = !stat.found && !stat.stack_empty;
      S_SCAN: cmd.scan_step = !stat.found;
      S_CHAIN: cmd.chain_step = !stat.chain_done;
      S_EMIT_START: cmd.emit_start = out_free;
      S_EMIT_CHAIN: cmd.emit_chain = out_free && !stat.chain_empty;
      S_EMIT_END: cmd.emit_end = out_free;
      S_EMIT_TOPO: cmd.emit_topo = out_free && !stat.fin_empty;
      S_EMIT_NONE: cmd.emit_none = out_free;
      S_WAIT: cmd.clear_graph = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

>>> sv/topological_sort_cycle_detect_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tuser: command; tdata: edge_from, edge_to, pad
// m_axis  | out | tuser: acyclic, no_node, edges_dropped; tdata: node, pad; tlast: last
// cfg     | in  | cfg_we, cfg_data: node_count
// Edge loads may follow back to back.
// A run keeps tready low until its last result is in the output register: every
// visited node scans the held edges in an address state and a compare state per entry,
// each root is tried in the root state and a cycle path is walked node by node.
// Results then leave from the emit states; a stalled output holds its register and
// only the emission waits on it. Reset is synchronous and clears the graph.
module topological_sort_cycle_detect_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // edge_from, edge_to, zero pad
  input  logic       s_axis_tuser,   // command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // node, zero pad
  output logic [2:0] m_axis_tuser,   // acyclic, no_node, edges_dropped
  output logic       m_axis_tlast
);
  import tscd_pkg::*;
  logic [5:0] node_count;
  cmd_t cmd;
  stat_t stat;
  logic busy, in_fire, out_free, out_load;
  logic [9:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) node_count <= '0;
    else if (cfg_we) node_count <= cfg_data;
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  tscd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_run(s_axis_tuser),
    .nodes_zero(node_count == 6'd0), .out_free(out_free), .stat(stat),
    .cmd(cmd), .busy(busy)
  );

  tscd_datapath u_dp (
    .clk(clk), .rst(rst), .node_count(node_count),
    .edge_from(s_axis_tdata[5:0]), .edge_to(s_axis_tdata[11:6]),
    .cmd(cmd), .stat(stat), .out_data(out_data), .out_load(out_load)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (out_load) begin
      m_axis_tuser <= {out_data[8], out_data[7], out_data[0]};
      m_axis_tdata <= {2'b00, out_data[6:1]};
      m_axis_tlast <= out_data[9];
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input accepted while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("output overwritten");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(busy)) |-> !out_load) else $error("result while idle");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import tscd_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [5:0] src;
    logic [5:0] dst;
  } edge_item_t;

  typedef struct packed {
    logic       acyclic;
    logic [5:0] node;
    logic       no_node;
    logic       dropped;
    logic       last;
  } order_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  edge_item_t  pending_q[$];
  order_item_t order_q[$];

  // Shadow of the graph held by the block.
  logic [5:0] src_mem[MAX_EDGES];
  logic [5:0] dst_mem[MAX_EDGES];
  int         edge_cnt;
  bit         overflow;
  int         node_cfg;

  int  burst_left;
  int  gap_left;
  int  stall_mode;
  int  mode_left;
  int  idle_cycles;
  bit  failed;
  int  total;

  localparam int WATCHDOG = 200000;

  topological_sort_cycle_detect_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic push_order(logic acyc, logic [5:0] nd, logic none, logic lst);
    order_item_t r;
    r.acyclic = acyc;
    r.node    = nd;
    r.no_node = none;
    r.dropped = overflow;
    r.last    = lst;
    order_q = {order_q, r};
  endtask

  // Depth-first search with white/grey/black marking over the shadow graph.
  task automatic sort_graph(int n);
    logic [1:0] colour[MAX_NODES];
    int parent[MAX_NODES];
    int stk[MAX_NODES];
    int cursor[MAX_NODES];
    int fin[MAX_NODES];
    int chain[MAX_NODES];
    int fc, sp, v, e, u, cn, i, cyc_start, cyc_end;
    bit found;
    fc = 0;
    found = 0;
    cyc_start = 0;
    cyc_end = 0;
    for (i = 0; i < MAX_NODES; i++) colour[i] = WHITE;
    for (int root = 0; root < n && !found; root++) begin
      if (colour[root] != WHITE) continue;
      colour[root] = GREY;
      stk[0] = root;
      cursor[0] = 0;
      sp = 1;
      while (sp > 0 && !found) begin
        v = stk[sp-1];
        e = cursor[sp-1];
        while (e < edge_cnt && !(src_mem[e] == v && dst_mem[e] < n)) e++;
        if (e >= edge_cnt) begin
          colour[v] = BLACK;
          if (fc < MAX_NODES) begin
            fin[fc] = v;
            fc++;
          end
          sp--;
        end else begin
          u = dst_mem[e];
          cursor[sp-1] = e + 1;
          if (colour[u] == WHITE) begin
            if (sp < MAX_NODES) begin
              parent[u] = v;
              colour[u] = GREY;
              stk[sp] = u;
              cursor[sp] = 0;
              sp++;
            end
          end else if (colour[u] == GREY) begin
            cyc_start = u;
            cyc_end = v;
            found = 1;
          end
        end
      end
    end
    if (found) begin
      cn = 0;
      i = cyc_end;
      while (i != cyc_start && cn < MAX_NODES) begin
        chain[cn] = i;
        cn++;
        i = parent[i] % MAX_NODES;
      end
      push_order(1'b0, cyc_start[5:0], 1'b0, 1'b0);
      while (cn > 0) begin
        cn--;
        push_order(1'b0, chain[cn][5:0], 1'b0, 1'b0);
      end
      push_order(1'b0, cyc_start[5:0], 1'b0, 1'b1);
    end else begin
      while (fc > 0) begin
        fc--;
        push_order(1'b1, fin[fc][5:0], 1'b0, fc == 0);
      end
    end
  endtask

  task automatic apply_item(edge_item_t it);
    int n;
    n = (node_cfg > MAX_NODES) ? MAX_NODES : node_cfg;
    if (!it.cmd) begin
      if (it.src >= n || it.dst >= n) return;
      if (edge_cnt >= MAX_EDGES) begin
        overflow = 1;
        return;
      end
      src_mem[edge_cnt] = it.src;
      dst_mem[edge_cnt] = it.dst;
      edge_cnt++;
    end else begin
      if (n == 0) push_order(1'b1, 6'd0, 1'b1, 1'b1);
      else sort_graph(n);
      edge_cnt = 0;
      overflow = 0;
    end
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 16'd0;
      s_axis_tuser <= 1'b0;
      burst_left <= $urandom_range(1, 20);
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_item({s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6]});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          edge_item_t it;
          it = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= it.cmd;
          s_axis_tdata <= {4'd0, it.dst, it.src};
          total++;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and result check.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
      if (m_axis_tvalid && m_axis_tready) begin
        order_item_t got;
        order_item_t want;
        got = {m_axis_tuser[0], m_axis_tdata[5:0], m_axis_tuser[1], m_axis_tuser[2],
               m_axis_tlast};
        if (order_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %p", $time, got);
          failed = 1;
        end else begin
          want = order_q.pop_front();
          if (got.acyclic !== want.acyclic || got.node !== want.node ||
              got.no_node !== want.no_node || got.dropped !== want.dropped ||
              got.last !== want.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            failed = 1;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (pending_q.size() == 0 && order_q.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("[topological_sort_cycle_detect_core] ERROR");
        $finish;
      end
    end
  end

  task automatic add_edge(int a, int b);
    edge_item_t it;
    it.cmd = 1'b0;
    it.src = a[5:0];
    it.dst = b[5:0];
    pending_q = {pending_q, it};
  endtask

  task automatic add_run();
    edge_item_t it;
    it.cmd = 1'b1;
    it.src = $urandom_range(0, 63);
    it.dst = $urandom_range(0, 63);
    pending_q = {pending_q, it};
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || order_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_nodes(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    node_cfg = v;
  endtask

  // A random graph: mostly acyclic with one orientation, sometimes with back edges.
  task automatic random_graph(int nn, int ne);
    bit dag, up;
    int a, b, t;
    dag = ($urandom_range(0, 2) != 0);
    up = $urandom_range(0, 1);
    for (int k = 0; k < ne; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, nn - 1);
        b = $urandom_range(0, nn - 1);
        if (dag) begin
          if (a == b) continue;
          if ((a > b) == up) begin
            t = a;
            a = b;
            b = t;
          end
        end
      end
      add_edge(a, b);
    end
    add_run();
  endtask

  initial begin
    int nn;
    failed = 0;
    total = 0;
    node_cfg = 0;
    edge_cnt = 0;
    overflow = 0;
    cfg_we = 1'b0;
    cfg_data = 6'd0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty graph gives one marker item.
    add_edge(0, 0);
    add_run();
    set_nodes(1);
    add_edge(0, 0);
    add_run();
    set_nodes(63);
    add_edge(63, 63);
    add_edge(31, 0);
    add_edge(0, 31);
    add_run();
    set_nodes(5);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    add_run();
    add_edge(4, 3);
    add_edge(3, 1);
    add_edge(1, 0);
    add_run();
    // Edges loaded with a large count, then the count shrinks before the run.
    set_nodes(32);
    add_edge(0, 20);
    add_edge(20, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    add_edge(1, 0);
    set_nodes(3);
    add_run();

    while (total + pending_q.size() < 165) begin
      case ($urandom_range(0, 5))
        0: nn = 63;
        1: nn = $urandom_range(0, 2);
        default: nn = $urandom_range(1, 33);
      endcase
      set_nodes(nn);
      repeat ($urandom_range(1, 3)) random_graph((nn == 0) ? 1 : nn, $urandom_range(0, 20));
    end
    set_nodes(0);
    drain();

    if (!failed) begin
      $display("[topological_sort_cycle_detect_core] OK");
    end else begin
      $display("[topological_sort_cycle_detect_core] ERROR");
    end
    $finish;
  end
endmodule
